FILE: rtl/core/region_coverage_statistics_defines.svh
// assertion macros for the region coverage statistics rtl
// no dependencies; included by region_coverage_statistics.sv, which checks its own logic
`ifndef REGION_COVERAGE_STATISTICS_DEFINES_SVH
`define REGION_COVERAGE_STATISTICS_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RCS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define RCS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/rcs_pkg.sv
// types and constants for the region coverage statistics block
// no dependencies
package rcs_pkg;

  localparam int VAL_W    = 16;
  localparam int NUM_THR  = 4;
  localparam int THR_CNT_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int SUM_OUT_W = 28;
  localparam int MEAN_W   = 20;
  localparam int PCT_W    = 10;
  localparam int BIT_W    = 4;
  localparam int DIV_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THR_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR_0     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR_3     = 3'd4;

  localparam logic [THR_CNT_W-1:0] THR_COUNT_RST = 3'd4;
  localparam logic [VAL_W-1:0] THR_RST [NUM_THR] = '{16'd10, 16'd20, 16'd40, 16'd60};

  // division slots: mean first, then one per threshold
  localparam logic [DIV_IDX_W-1:0] DIV_MEAN = 3'd0;
  localparam logic [DIV_IDX_W-1:0] DIV_LAST = 3'd4;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_KICK,
    ST_SELECT,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT
  } top_state_t;

  typedef enum logic [1:0] {
    SEL_IDLE,
    SEL_SCAN,
    SEL_DRAIN,
    SEL_UPDATE
  } sel_state_t;

endpackage

FILE: rtl/core/rcs_divider.sv
// iterative restoring divider, one quotient bit per cycle
// depends on nothing outside itself
module rcs_divider #(
  parameter int NUM_W = 34,
  parameter int DEN_W = 14
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] work;
  logic [DEN_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem, work[NUM_W-1]};
  assign fits  = trial >= {1'b0, den};
  assign quo   = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(NUM_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift into the low end of the dividend register
  always_ff @(posedge clk) begin
    if (start) begin
      work <= num;
      rem  <= '0;
    end else if (cnt != '0) begin
      work <= {work[NUM_W-2:0], fits};
      rem  <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
    end
  end

endmodule

FILE: rtl/core/rcs_select.sv
// value store and bitwise radix selection of three order statistics
// depends on rcs_pkg
module rcs_select
  import rcs_pkg::*;
#(
  parameter int MAX_REGION = 4096
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   wr_en,
  input  logic [$clog2(MAX_REGION+1)-1:0]        wr_addr,
  input  logic [VAL_W-1:0]                       wr_data,
  input  logic                                   start,
  input  logic [$clog2(MAX_REGION+1)-1:0]        n,
  input  logic [$clog2(MAX_REGION+1)-1:0]        k0,
  input  logic [$clog2(MAX_REGION+1)-1:0]        k1,
  input  logic [$clog2(MAX_REGION+1)-1:0]        k2,
  output logic                                   done,
  output logic [VAL_W-1:0]                       q0,
  output logic [VAL_W-1:0]                       q1,
  output logic [VAL_W-1:0]                       q2
);

  localparam int CNT_W = $clog2(MAX_REGION + 1);
  localparam int AW    = (MAX_REGION > 1) ? $clog2(MAX_REGION) : 1;

  sel_state_t state, state_next;

  logic [VAL_W-1:0] mem [MAX_REGION];
  logic [VAL_W-1:0] rd_data;
  logic             rd_vld;
  logic [CNT_W-1:0] rd_idx;
  logic [CNT_W-1:0] n_reg;
  logic [BIT_W-1:0] bitpos;
  logic [VAL_W-1:0] prefix [3];
  logic [CNT_W-1:0] kr [3];
  logic [CNT_W-1:0] zeros [3];
  logic [VAL_W-1:0] low_mask;
  logic             scan, update, last_issue;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[AW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_idx[AW-1:0]];
  end

  assign last_issue = rd_idx == n_reg - 1'b1;

  always_comb begin
    state_next = state;
    unique case (state)
      SEL_IDLE:   if (start) state_next = SEL_SCAN;
      SEL_SCAN:   if (last_issue) state_next = SEL_DRAIN;
      SEL_DRAIN:  state_next = SEL_UPDATE;
      SEL_UPDATE: state_next = (bitpos == '0) ? SEL_IDLE : SEL_SCAN;
      default:    state_next = SEL_IDLE;
    endcase
  end

  always_comb begin
    scan   = 1'b0;
    update = 1'b0;
    unique case (state)
      SEL_SCAN:   scan = 1'b1;
      SEL_UPDATE: update = 1'b1;
      default:    ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= SEL_IDLE;
      rd_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= scan;
      done   <= update && bitpos == '0;
    end
  end

  // entries that share the prefix above the bit and hold a zero there
  assign low_mask = (VAL_W'(1) << bitpos) - 1'b1;

  always_ff @(posedge clk) begin
    if (start) begin
      n_reg  <= n;
      rd_idx <= '0;
      bitpos <= BIT_W'(VAL_W - 1);
      kr[0]  <= k0;
      kr[1]  <= k1;
      kr[2]  <= k2;
      for (int i = 0; i < 3; i++) begin
        prefix[i] <= '0;
        zeros[i]  <= '0;
      end
    end else begin
      if (scan) begin
        rd_idx <= rd_idx + 1'b1;
      end
      for (int i = 0; i < 3; i++) begin
        if (rd_vld && ((rd_data & ~low_mask) == prefix[i])) begin
          zeros[i] <= zeros[i] + 1'b1;
        end
        if (update) begin
          zeros[i] <= '0;
          if (kr[i] >= zeros[i]) begin
            kr[i]     <= kr[i] - zeros[i];
            prefix[i] <= prefix[i] | (VAL_W'(1) << bitpos);
          end
        end
      end
      if (update) begin
        rd_idx <= '0;
        bitpos <= bitpos - 1'b1;
      end
    end
  end

  assign q0 = prefix[0];
  assign q1 = prefix[1];
  assign q2 = prefix[2];

endmodule

FILE: rtl/core/region_coverage_statistics.sv
// Region coverage statistics, top level.
// The input channel (in_valid / in_stall) carries one depth per item with a
// last flag that closes the region. While loading, an item is taken every
// cycle and updates count, sum, min, max and the per-threshold counts, and
// the value is written to the store. A region holds up to MAX_REGION values;
// later ones are dropped and flag overflow_seen.
// After the last item the block stalls its input: a radix selection finds
// the three quartile values in 16 passes over the store through the single
// store read port, then one shared serial divider forms the mean and the
// four percentages in turn. The result sits in an output register
// (out_valid / out_stall); the next region loads while it waits, and only a
// finished result that cannot be handed over holds the block. Configuration
// (cfg_wen, cfg_index, cfg_data) must be written by the user between regions;
// the block itself does not enforce this. Reset restores the default
// thresholds and empties the region; the store holds no valid state.
`include "region_coverage_statistics_defines.svh"
module region_coverage_statistics
  import rcs_pkg::*;
#(
  parameter int MAX_REGION = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [VAL_W-1:0]     coverage_value,
  input  logic                 last_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SUM_OUT_W-1:0] sum_coverage,
  output logic [MEAN_W-1:0]    mean_tenths,
  output logic [VAL_W-1:0]     lower_quartile,
  output logic [VAL_W-1:0]     median_value,
  output logic [VAL_W-1:0]     upper_quartile,
  output logic [VAL_W-1:0]     minimum_value,
  output logic [VAL_W-1:0]     maximum_value,
  output logic [PCT_W-1:0]     pct_above_0,
  output logic [PCT_W-1:0]     pct_above_1,
  output logic [PCT_W-1:0]     pct_above_2,
  output logic [PCT_W-1:0]     pct_above_3,
  output logic                 overflow_seen
);

  localparam int CNT_W = $clog2(MAX_REGION + 1);
  localparam int SUM_W = (VAL_W + CNT_W > SUM_OUT_W) ? VAL_W + CNT_W : SUM_OUT_W;
  localparam int NUM_W = SUM_W + 6;
  localparam int DEN_W = CNT_W + 1;

  top_state_t state, state_next;

  logic [THR_CNT_W-1:0] thr_count;
  logic [VAL_W-1:0]     thr [NUM_THR];
  logic [CNT_W-1:0]     item_count;
  logic [SUM_W-1:0]     running_sum;
  logic [VAL_W-1:0]     running_min, running_max;
  logic [CNT_W-1:0]     above [NUM_THR];
  logic                 overflow_flag;

  logic                 in_fire, room, store_wr, sel_start, sel_done;
  logic                 div_start, div_done, emit;
  logic [CNT_W-1:0]     nm1;
  logic [CNT_W+1:0]     nm1_x3;
  logic [VAL_W-1:0]     q0, q1, q2;
  logic [DIV_IDX_W-1:0] div_idx;
  logic [NUM_W-1:0]     div_num, div_quo;
  logic [MEAN_W-1:0]    res_mean;
  logic [PCT_W-1:0]     res_pct [NUM_THR];
  logic [CNT_W-1:0]     above_sel;

  assign in_fire  = in_valid && !in_stall;
  assign room     = item_count != CNT_W'(MAX_REGION);
  assign store_wr = in_fire && room;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:      if (in_fire && last_value) state_next = ST_KICK;
      ST_KICK:      state_next = ST_SELECT;
      ST_SELECT:    if (sel_done) state_next = ST_DIV_START;
      ST_DIV_START: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) state_next = (div_idx == DIV_LAST) ? ST_EMIT : ST_DIV_START;
      end
      ST_EMIT:      if (!out_valid || !out_stall) state_next = ST_LOAD;
      default:      state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    sel_start = 1'b0;
    div_start = 1'b0;
    emit      = 1'b0;
    unique case (state)
      ST_LOAD:      in_stall = 1'b0;
      ST_KICK:      sel_start = 1'b1;
      ST_DIV_START: div_start = 1'b1;
      ST_EMIT:      emit = !out_valid || !out_stall;
      default:      ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      out_valid <= 1'b0;
      thr_count <= THR_COUNT_RST;
      for (int j = 0; j < NUM_THR; j++) begin
        thr[j] <= THR_RST[j];
      end
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_wen) begin
        if (cfg_index == REG_THR_COUNT) begin
          thr_count <= cfg_data[THR_CNT_W-1:0];
        end else if (cfg_index >= REG_THR_0 && cfg_index <= REG_THR_3) begin
          thr[2'(cfg_index - REG_THR_0)] <= cfg_data;
        end
      end
    end
  end

  // region accumulators
  always_ff @(posedge clk) begin
    if (rst || emit) begin
      item_count    <= '0;
      running_sum   <= '0;
      running_min   <= '1;
      running_max   <= '0;
      overflow_flag <= 1'b0;
      for (int j = 0; j < NUM_THR; j++) begin
        above[j] <= '0;
      end
    end else if (in_fire) begin
      if (room) begin
        item_count  <= item_count + 1'b1;
        running_sum <= running_sum + SUM_W'(coverage_value);
        if (coverage_value < running_min) running_min <= coverage_value;
        if (coverage_value > running_max) running_max <= coverage_value;
        for (int j = 0; j < NUM_THR; j++) begin
          if (coverage_value > thr[j]) above[j] <= above[j] + 1'b1;
        end
      end else begin
        overflow_flag <= 1'b1;
      end
    end
  end

  assign nm1    = item_count - 1'b1;
  assign nm1_x3 = (CNT_W+2)'(nm1) + (CNT_W+2)'({nm1, 1'b0});

  rcs_select #(
    .MAX_REGION(MAX_REGION)
  ) u_select (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (store_wr),
    .wr_addr (item_count),
    .wr_data (coverage_value),
    .start   (sel_start),
    .n       (item_count),
    .k0      (nm1 >> 2),
    .k1      (nm1 >> 1),
    .k2      (nm1_x3[CNT_W+1:2]),
    .done    (sel_done),
    .q0      (q0),
    .q1      (q1),
    .q2      (q2)
  );

  // mean: (20*sum + n) / 2n; percentage: (2000*above + n) / 2n
  // 2000 is formed as 2048 - 32 - 16
  assign above_sel = above[2'(div_idx - 1'b1)];
  always_comb begin
    if (div_idx == DIV_MEAN) begin
      div_num = (NUM_W'(running_sum) << 4) + (NUM_W'(running_sum) << 2)
              + NUM_W'(item_count);
    end else begin
      div_num = (NUM_W'(above_sel) << 11) - (NUM_W'(above_sel) << 5)
              - (NUM_W'(above_sel) << 4) + NUM_W'(item_count);
    end
  end

  rcs_divider #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_divider (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   ({item_count, 1'b0}),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst || sel_start) begin
      div_idx <= DIV_MEAN;
    end else if (div_done) begin
      div_idx <= div_idx + 1'b1;
      if (div_idx == DIV_MEAN) begin
        res_mean <= div_quo[MEAN_W-1:0];
      end else begin
        res_pct[2'(div_idx - 1'b1)] <= div_quo[PCT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      sum_coverage   <= running_sum[SUM_OUT_W-1:0];
      mean_tenths    <= res_mean;
      lower_quartile <= q0;
      median_value   <= q1;
      upper_quartile <= q2;
      minimum_value  <= running_min;
      maximum_value  <= running_max;
      pct_above_0    <= (thr_count > 3'd0) ? res_pct[0] : '0;
      pct_above_1    <= (thr_count > 3'd1) ? res_pct[1] : '0;
      pct_above_2    <= (thr_count > 3'd2) ? res_pct[2] : '0;
      pct_above_3    <= (thr_count > 3'd3) ? res_pct[3] : '0;
      overflow_seen  <= overflow_flag;
    end
  end

  `RCS_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, item_count <= CNT_W'(MAX_REGION), "count past store depth")
  `RCS_ASSERT_IMP(a_min_max, clk, rst, item_count != '0, running_min <= running_max, "min above max")
  `RCS_ASSERT_IMP(a_emit_src, clk, rst, $rose(out_valid), $past(state) == ST_EMIT, "result outside emit")
  `RCS_ASSERT_NXT(a_last_stalls, clk, rst, in_fire && last_value, in_stall, "input open after last item")

endmodule

FILE: tb/sv/testbench.sv
// testbench for region_coverage_statistics: depth regions with random gaps and stalls
// results checked field by field against a behavioral predictor; depends on rcs_pkg and the rtl
`timescale 1ns / 100ps
module testbench;
  import rcs_pkg::*;

  localparam int STORE_DEPTH = 4096;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 270;
  localparam logic [CFG_IDX_W-1:0] REG_PAST_END = REG_THR_3 + 3'd1;

  typedef struct {
    logic [SUM_OUT_W-1:0] sum;
    logic [MEAN_W-1:0]    mean;
    logic [VAL_W-1:0]     lq;
    logic [VAL_W-1:0]     med;
    logic [VAL_W-1:0]     uq;
    logic [VAL_W-1:0]     vmin;
    logic [VAL_W-1:0]     vmax;
    logic [PCT_W-1:0]     pct [NUM_THR];
    logic                 ovf;
  } region_stats_t;

  typedef struct {
    logic [VAL_W-1:0] depth;
    logic             last;
    bit               typed;
    region_stats_t    stats;
  } depth_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VAL_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [VAL_W-1:0]     coverage_value = '0;
  logic                 last_value = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [SUM_OUT_W-1:0] sum_coverage;
  logic [MEAN_W-1:0]    mean_tenths;
  logic [VAL_W-1:0]     lower_quartile, median_value, upper_quartile;
  logic [VAL_W-1:0]     minimum_value, maximum_value;
  logic [PCT_W-1:0]     pct_above_0, pct_above_1, pct_above_2, pct_above_3;
  logic                 overflow_seen;

  region_coverage_statistics DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [THR_CNT_W-1:0] thr_count_q = THR_COUNT_RST;
  logic [VAL_W-1:0]     thr_q [NUM_THR];
  logic [VAL_W-1:0]     depth_store [$];
  longint               depth_sum;
  logic [VAL_W-1:0]     depth_min, depth_max;
  int                   above_cnt [NUM_THR];
  bit                   dropped;

  region_stats_t pending_stats [$];
  int  fail_count = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  cycle_count = 0;

  task automatic clear_region();
    depth_store.delete();
    depth_sum = 0;
    depth_min = '1;
    depth_max = '0;
    foreach (above_cnt[j]) above_cnt[j] = 0;
    dropped = 1'b0;
  endtask

  // fold one accepted depth into the region; on last, queue the region's stats
  task automatic absorb_depth(logic [VAL_W-1:0] v, logic last, bit typed, region_stats_t typed_stats);
    region_stats_t r;
    logic [VAL_W-1:0] sorted [$];
    longint n;
    int used;
    if (depth_store.size() < STORE_DEPTH) begin
      depth_store.push_back(v);
      depth_sum += v;
      if (v < depth_min) depth_min = v;
      if (v > depth_max) depth_max = v;
      for (int j = 0; j < NUM_THR; j++) if (v > thr_q[j]) above_cnt[j]++;
    end else begin
      dropped = 1'b1;
    end
    if (!last) return;
    n = depth_store.size();
    used = (thr_count_q > NUM_THR) ? NUM_THR : thr_count_q;
    r.sum = '0; r.mean = '0; r.lq = '0; r.med = '0; r.uq = '0; r.vmin = '0; r.vmax = '0;
    foreach (r.pct[j]) r.pct[j] = '0;
    if (n > 0) begin
      sorted = depth_store;
      sorted.sort();
      r.sum  = SUM_OUT_W'(depth_sum);
      r.mean = MEAN_W'((20 * depth_sum + n) / (2 * n));
      r.lq   = sorted[(n - 1) / 4];
      r.med  = sorted[(n - 1) / 2];
      r.uq   = sorted[(3 * (n - 1)) / 4];
      r.vmin = depth_min;
      r.vmax = depth_max;
      for (int j = 0; j < used; j++)
        r.pct[j] = PCT_W'((2000 * longint'(above_cnt[j]) + n) / (2 * n));
    end
    r.ovf = dropped;
    if (typed) pending_stats.push_back(typed_stats);
    else pending_stats.push_back(r);
    clear_region();
  endtask

  task automatic send_depth(logic [VAL_W-1:0] v, logic last, bit typed, region_stats_t ts);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    coverage_value <= v;
    last_value     <= last;
    do @(posedge clk); while (in_stall);
    absorb_depth(v, last, typed, ts);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_wen <= 1'b0;
    if (idx == REG_THR_COUNT) thr_count_q = data[THR_CNT_W-1:0];
    else if (idx >= REG_THR_0 && idx <= REG_THR_3) thr_q[idx - REG_THR_0] = data;
  endtask

  // hold the sender until every region result is out, then let the block settle
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_stats.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [VAL_W-1:0] pick_depth();
    case ($urandom_range(4))
      0: return $urandom_range(0, 80);
      1: return $urandom_range(1) ? '1 : '0;
      2: return thr_q[$urandom_range(NUM_THR - 1)] + $urandom_range(2) - 1;
      3: return VAL_W'($urandom) >> $urandom_range(VAL_W - 1);
      default: return VAL_W'($urandom);
    endcase
  endfunction

  task automatic random_regions(int count);
    region_stats_t none;
    int sent = 0;
    int len;
    while (sent < count) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
      for (int i = 0; i < len; i++) send_depth(pick_depth(), i == len - 1, 1'b0, none);
      sent += len;
    end
  endtask

  task automatic random_config();
    write_reg(REG_THR_COUNT, VAL_W'($urandom_range(7)));
    for (int j = 0; j < NUM_THR; j++)
      write_reg(CFG_IDX_W'(REG_THR_0 + j),
                $urandom_range(3) == 0 ? VAL_W'($urandom) : VAL_W'($urandom_range(0, 90)));
  endtask

  task automatic check_field(string name, longint e, longint a);
    if (e != a) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      fail_count++;
    end
  endtask

  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  always @(posedge clk) begin
    region_stats_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_stats.size() == 0) begin
        $error("region result with none expected");
        fail_count++;
      end else begin
        e = pending_stats.pop_front();
        check_field("sum_coverage", e.sum, sum_coverage);
        check_field("mean_tenths", e.mean, mean_tenths);
        check_field("lower_quartile", e.lq, lower_quartile);
        check_field("median_value", e.med, median_value);
        check_field("upper_quartile", e.uq, upper_quartile);
        check_field("minimum_value", e.vmin, minimum_value);
        check_field("maximum_value", e.vmax, maximum_value);
        check_field("pct_above_0", e.pct[0], pct_above_0);
        check_field("pct_above_1", e.pct[1], pct_above_1);
        check_field("pct_above_2", e.pct[2], pct_above_2);
        check_field("pct_above_3", e.pct[3], pct_above_3);
        check_field("overflow_seen", e.ovf, overflow_seen);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    depth_row_t    rows [$];
    depth_row_t    row;
    region_stats_t full, zero;
    foreach (thr_q[j]) thr_q[j] = THR_RST[j];
    clear_region();

    full.sum = 65535; full.mean = 655350; full.lq = '1; full.med = '1; full.uq = '1;
    full.vmin = '1; full.vmax = '1; foreach (full.pct[j]) full.pct[j] = 1000; full.ovf = 1'b0;
    zero.sum = '0; zero.mean = '0; zero.lq = '0; zero.med = '0; zero.uq = '0;
    zero.vmin = '0; zero.vmax = '0; foreach (zero.pct[j]) zero.pct[j] = '0; zero.ovf = 1'b0;

    // single-item regions at the extremes, then threshold ties and duplicates
    rows.push_back('{16'hFFFF, 1'b1, 1'b1, full});
    rows.push_back('{16'h0000, 1'b1, 1'b1, zero});
    foreach (row.stats.pct[j]) row.stats.pct[j] = '0;
    row.typed = 1'b0;
    row.last = 1'b0;
    row.depth = 10;  rows.push_back(row);
    row.depth = 11;  rows.push_back(row);
    row.depth = 20;  rows.push_back(row);
    row.depth = 21;  row.last = 1'b1; rows.push_back(row);
    row.last = 1'b0;
    row.depth = 40;  rows.push_back(row);
    row.depth = 60;  rows.push_back(row);
    row.depth = 61;  rows.push_back(row);
    row.depth = 0;   rows.push_back(row);
    row.depth = '1;  row.last = 1'b1; rows.push_back(row);
    row.last = 1'b0;
    row.depth = 7;   rows.push_back(row);
    row.depth = 7;   rows.push_back(row);
    row.depth = 7;   row.last = 1'b1; rows.push_back(row);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_depth(rows[i].depth, rows[i].last, rows[i].typed, rows[i].stats);
    drain_results();

    // no thresholds in use, and a write past the register list that must do nothing
    write_reg(REG_THR_COUNT, 16'd0);
    write_reg(REG_PAST_END, 16'h0001);
    write_reg(REG_PAST_END + 3'd1, 16'h0002);
    send_depth(16'd500, 1'b0, 1'b0, zero);
    send_depth(16'd3, 1'b1, 1'b0, zero);
    drain_results();

    // count above the number of thresholds, thresholds at both ends
    write_reg(REG_THR_COUNT, 16'd7);
    write_reg(REG_THR_0, 16'd0);
    write_reg(REG_THR_0 + 3'd1, '1);
    write_reg(REG_THR_0 + 3'd2, 16'd1);
    write_reg(REG_THR_0 + 3'd3, 16'hFFFE);
    send_depth(16'd0, 1'b0, 1'b0, zero);
    send_depth(16'hFFFF, 1'b0, 1'b0, zero);
    send_depth(16'd1, 1'b1, 1'b0, zero);

    // full store at the largest sum, then dropped values, last flag on a dropped one
    for (int i = 0; i < STORE_DEPTH; i++) send_depth('1, 1'b0, 1'b0, zero);
    for (int i = 0; i < 4; i++) send_depth(VAL_W'($urandom), i == 3, 1'b0, zero);
    drain_results();

    send_idle_pct = 28; recv_idle_pct = 57;
    random_config();
    random_regions(PHASE_ITEMS);
    drain_results();

    send_idle_pct = 57; recv_idle_pct = 28;
    random_config();
    random_regions(PHASE_ITEMS);
    drain_results();

    send_idle_pct = 0; recv_idle_pct = 0;
    random_config();
    random_regions(PHASE_ITEMS);
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_stats.size() == 0);
    repeat (50) @(posedge clk);

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
